// ===== design/gf2d_pkg.sv =====
// Shared widths, register indexes and sideband types for the 2-D gravity pipeline.
`timescale 1ns / 1ps
package gf2d_pkg;

    localparam int POS_W  = 32;   // positions, masses, G, forces
    localparam int D2_W   = 65;   // exact squared distance
    localparam int SQ_W   = 64;   // clamp registers and clamped distance
    localparam int NUM_W  = 96;   // G * mass_a * mass_b, magnitude * |d|
    localparam int MAG_W  = 64;   // capped magnitude
    localparam int SQRT_W = 34;   // floor square root of the squared distance
    localparam int IDX_W  = 8;    // configuration index

    localparam logic [IDX_W-1:0] CFG_GRAVITY = 8'd0;
    localparam logic [IDX_W-1:0] CFG_MIN_D2  = 8'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_D2  = 8'd2;

    // travels through the square-root pipeline
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [SQ_W-1:0]  clamped;
        logic             neg_x;
        logic             neg_y;
        logic             zero_x;
        logic             zero_y;
        logic [POS_W-1:0] abs_x;
        logic [POS_W-1:0] abs_y;
    } t_sq_side;

    // travels through the magnitude divider
    typedef struct packed {
        logic [SQRT_W-1:0] root;
        logic              den_zero;
        logic              num_nonzero;
        logic              neg_x;
        logic              neg_y;
        logic              zero_x;
        logic              zero_y;
        logic [POS_W-1:0]  abs_x;
        logic [POS_W-1:0]  abs_y;
    } t_md_side;

    // travels through each component divider
    typedef struct packed {
        logic neg;
        logic zero;
    } t_cp_side;

endpackage

// ===== design/gf2d_div.sv =====
// Restoring divider, one quotient bit per pipeline stage, with a sideband.
`timescale 1ns / 1ps
module gf2d_div #(
    parameter int NW = 96,
    parameter int DW = 64,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [SW-1:0] o_side
);

    logic          r_vld  [0:NW-1];
    logic [DW-1:0] r_rem  [0:NW-1];
    logic [NW-1:0] r_nq   [0:NW-1];   // numerator bits still to go, quotient shifted in
    logic [DW-1:0] r_den  [0:NW-1];
    logic [SW-1:0] r_side [0:NW-1];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          a_vld;
        logic [DW-1:0] a_rem;
        logic [NW-1:0] a_nq;
        logic [DW-1:0] a_den;
        logic [SW-1:0] a_side;
        logic [DW:0]   t;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign a_vld  = i_valid;
            assign a_rem  = '0;
            assign a_nq   = i_num;
            assign a_den  = i_den;
            assign a_side = i_side;
        end else begin : g_next
            assign a_vld  = r_vld[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_nq   = r_nq[k-1];
            assign a_den  = r_den[k-1];
            assign a_side = r_side[k-1];
        end

        assign t    = {a_rem, a_nq[NW-1]};
        assign diff = t - {1'b0, a_den};
        assign ge   = (t >= {1'b0, a_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? diff[DW-1:0] : t[DW-1:0];
            r_nq[k]   <= {a_nq[NW-2:0], ge};
            r_den[k]  <= a_den;
            r_side[k] <= a_side;
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

// ===== design/gf2d_sqrt.sv =====
// Floor integer square root, two radicand bits per pipeline stage, with a sideband.
`timescale 1ns / 1ps
module gf2d_sqrt #(
    parameter int SW = 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [2*gf2d_pkg::SQRT_W-1:0] i_val,
    input  logic [SW-1:0]                 i_side,
    output logic                          o_valid,
    output logic [gf2d_pkg::SQRT_W-1:0]   o_root,
    output logic [SW-1:0]                 o_side
);

    localparam int RW = gf2d_pkg::SQRT_W;
    localparam int VW = 2 * RW;

    logic          r_vld  [0:RW-1];
    logic [RW+1:0] r_rem  [0:RW-1];
    logic [RW-1:0] r_res  [0:RW-1];
    logic [VW-1:0] r_val  [0:RW-1];
    logic [SW-1:0] r_side [0:RW-1];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic          a_vld;
        logic [RW+1:0] a_rem;
        logic [RW-1:0] a_res;
        logic [VW-1:0] a_val;
        logic [SW-1:0] a_side;
        logic [RW+3:0] t;
        logic [RW+3:0] trial;
        logic [RW+3:0] diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign a_vld  = i_valid;
            assign a_rem  = '0;
            assign a_res  = '0;
            assign a_val  = i_val;
            assign a_side = i_side;
        end else begin : g_next
            assign a_vld  = r_vld[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_res  = r_res[k-1];
            assign a_val  = r_val[k-1];
            assign a_side = r_side[k-1];
        end

        assign t     = {a_rem, a_val[VW-1:VW-2]};
        assign trial = {2'b00, a_res, 2'b01};
        assign diff  = t - trial;
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? diff[RW+1:0] : t[RW+1:0];
            r_res[k]  <= {a_res[RW-2:0], ge};
            r_val[k]  <= {a_val[VW-3:0], 2'b00};
            r_side[k] <= a_side;
        end
    end

    assign o_valid = r_vld[RW-1];
    assign o_root  = r_res[RW-1];
    assign o_side  = r_side[RW-1];

endmodule

// ===== design/gravitational_force_2d.sv =====
// Top level: pipelined pairwise Newtonian force in two dimensions, fixed point.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -----------------------------------------
//  item      in         start && !busy            i_a_x i_a_y i_b_x i_b_y i_mass_a i_mass_b
//  result    out        o_valid (one-cycle pulse) o_force_x o_force_y o_saturated
//  config    in         i_cfg_we                  i_cfg_idx i_cfg_data
//
//  One item enters every cycle; busy stays low. Each transfer passes through
//  4 front stages (deltas, squares, mass products, clamp), 34 square-root
//  stages, 96 stages of the magnitude divider, 3 product stages, 96 stages
//  of the two component dividers and one output register.
//  Reset is synchronous, clears the valid bits and loads the configuration defaults.
//  The receiver cannot stall, so the pipeline never holds.
`timescale 1ns / 1ps
module gravitational_force_2d #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [31:0]             i_a_x,
    input  logic signed [31:0]             i_a_y,
    input  logic signed [31:0]             i_b_x,
    input  logic signed [31:0]             i_b_y,
    input  logic [31:0]                    i_mass_a,
    input  logic [31:0]                    i_mass_b,
    input  logic                           i_cfg_we,
    input  logic [gf2d_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [63:0]                    i_cfg_data,
    output logic                           o_valid,
    output logic signed [31:0]             o_force_x,
    output logic signed [31:0]             o_force_y,
    output logic                           o_saturated
);

    localparam int PW = gf2d_pkg::POS_W;
    localparam int NW = gf2d_pkg::NUM_W;
    localparam int QW = gf2d_pkg::SQ_W;
    localparam int MW = gf2d_pkg::MAG_W;
    localparam int RW = gf2d_pkg::SQRT_W;

    // ---------------------------------------------------------------- config
    logic [PW-1:0] r_gravity;
    logic [QW-1:0] r_min_d2;
    logic [QW-1:0] r_max_d2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gravity <= PW'(64'd1 << FRACTION_BITS);
            r_min_d2  <= QW'(64'd1 << (2 * FRACTION_BITS));
            r_max_d2  <= '1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                gf2d_pkg::CFG_GRAVITY: r_gravity <= i_cfg_data[PW-1:0];
                gf2d_pkg::CFG_MIN_D2:  r_min_d2  <= i_cfg_data;
                gf2d_pkg::CFG_MAX_D2:  r_max_d2  <= i_cfg_data;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign busy = 1'b0;

    // ---------------------------------------------------------------- stage 1: deltas
    logic [PW:0] dx_w, dy_w, adx_w, ady_w;
    assign dx_w  = {i_b_x[PW-1], i_b_x} - {i_a_x[PW-1], i_a_x};
    assign dy_w  = {i_b_y[PW-1], i_b_y} - {i_a_y[PW-1], i_a_y};
    assign adx_w = dx_w[PW] ? (~dx_w + 1'b1) : dx_w;
    assign ady_w = dy_w[PW] ? (~dy_w + 1'b1) : dy_w;

    logic          r1_vld;
    logic          r1_nx, r1_ny;
    logic [PW-1:0] r1_ax, r1_ay, r1_ma, r1_mb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else          r1_vld <= start && !busy;
    end

    always_ff @(posedge i_clk) begin
        r1_nx <= dx_w[PW];
        r1_ny <= dy_w[PW];
        r1_ax <= adx_w[PW-1:0];   // |delta| never exceeds 2^32 - 1
        r1_ay <= ady_w[PW-1:0];
        r1_ma <= i_mass_a;
        r1_mb <= i_mass_b;
    end

    // ---------------------------------------------------------------- stage 2: squares, G*ma
    logic          r2_vld, r2_nx, r2_ny;
    logic [PW-1:0] r2_ax, r2_ay, r2_mb;
    logic [63:0]   r2_sx, r2_sy, r2_gma;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else          r2_vld <= r1_vld;
    end

    always_ff @(posedge i_clk) begin
        r2_sx  <= 64'(r1_ax) * 64'(r1_ax);
        r2_sy  <= 64'(r1_ay) * 64'(r1_ay);
        r2_gma <= 64'(r_gravity) * 64'(r1_ma);
        r2_nx  <= r1_nx;
        r2_ny  <= r1_ny;
        r2_ax  <= r1_ax;
        r2_ay  <= r1_ay;
        r2_mb  <= r1_mb;
    end

    // ---------------------------------------------------------------- stage 3: D2, partial numerator
    logic          r3_vld, r3_nx, r3_ny;
    logic [PW-1:0] r3_ax, r3_ay;
    logic [64:0]   r3_d2;
    logic [63:0]   r3_plo, r3_phi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else          r3_vld <= r2_vld;
    end

    always_ff @(posedge i_clk) begin
        r3_d2  <= {1'b0, r2_sx} + {1'b0, r2_sy};
        r3_plo <= 64'(r2_gma[31:0])  * 64'(r2_mb);
        r3_phi <= 64'(r2_gma[63:32]) * 64'(r2_mb);
        r3_nx  <= r2_nx;
        r3_ny  <= r2_ny;
        r3_ax  <= r2_ax;
        r3_ay  <= r2_ay;
    end

    // ---------------------------------------------------------------- stage 4: clamp, numerator
    // lower bound first, then upper; an overflowed D2 always takes the upper bound
    logic below_min, above_max, min_over_max;
    logic [QW-1:0] clamp_w;
    assign below_min    = (r3_d2[64] == 1'b0) && (r3_d2[63:0] < r_min_d2);
    assign above_max    = r3_d2[64] || (r3_d2[63:0] > r_max_d2);
    assign min_over_max = (r_min_d2 > r_max_d2);

    always_comb begin
        if (below_min ? min_over_max : above_max) clamp_w = r_max_d2;
        else if (below_min)                       clamp_w = r_min_d2;
        else                                      clamp_w = r3_d2[63:0];
    end

    logic               r4_vld;
    logic [64:0]        r4_d2;
    gf2d_pkg::t_sq_side r4_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else          r4_vld <= r3_vld;
    end

    always_ff @(posedge i_clk) begin
        r4_d2           <= r3_d2;
        r4_side.num     <= {r3_phi, 32'd0} + {32'd0, r3_plo};
        r4_side.clamped <= clamp_w;
        r4_side.neg_x   <= r3_nx;
        r4_side.neg_y   <= r3_ny;
        r4_side.zero_x  <= (r3_ax == '0);
        r4_side.zero_y  <= (r3_ay == '0);
        r4_side.abs_x   <= r3_ax;
        r4_side.abs_y   <= r3_ay;
    end

    // ---------------------------------------------------------------- square root of unclamped D2
    logic                                sq_vld;
    logic [RW-1:0]                       sq_root;
    logic [$bits(gf2d_pkg::t_sq_side)-1:0] sq_side_raw;
    gf2d_pkg::t_sq_side                  sq_side;

    gf2d_sqrt #(
        .SW ($bits(gf2d_pkg::t_sq_side))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r4_vld),
        .i_val   ({{(2*RW-65){1'b0}}, r4_d2}),
        .i_side  (r4_side),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side_raw)
    );

    assign sq_side = gf2d_pkg::t_sq_side'(sq_side_raw);

    // ---------------------------------------------------------------- magnitude divider
    gf2d_pkg::t_md_side md_in;
    always_comb begin
        md_in.root        = sq_root;
        md_in.den_zero    = (sq_side.clamped == '0);
        md_in.num_nonzero = (sq_side.num != '0);
        md_in.neg_x       = sq_side.neg_x;
        md_in.neg_y       = sq_side.neg_y;
        md_in.zero_x      = sq_side.zero_x;
        md_in.zero_y      = sq_side.zero_y;
        md_in.abs_x       = sq_side.abs_x;
        md_in.abs_y       = sq_side.abs_y;
    end

    logic                                  md_vld;
    logic [NW-1:0]                         md_quo;
    logic [$bits(gf2d_pkg::t_md_side)-1:0] md_side_raw;
    gf2d_pkg::t_md_side                    md_side;

    gf2d_div #(
        .NW (NW),
        .DW (QW),
        .SW ($bits(gf2d_pkg::t_md_side))
    ) u_mag_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_num   (sq_side.num),
        .i_den   (sq_side.clamped),
        .i_side  (md_in),
        .o_valid (md_vld),
        .o_quo   (md_quo),
        .o_side  (md_side_raw)
    );

    assign md_side = gf2d_pkg::t_md_side'(md_side_raw);

    // ---------------------------------------------------------------- stage M1: cap magnitude
    // zero clamped distance: any nonzero numerator gives the cap
    logic [MW-1:0] mag_w;
    always_comb begin
        if (md_side.den_zero)        mag_w = md_side.num_nonzero ? '1 : '0;
        else if (md_quo[NW-1:MW] != '0) mag_w = '1;
        else                         mag_w = md_quo[MW-1:0];
    end

    logic               r5_vld;
    logic [MW-1:0]      r5_mag;
    gf2d_pkg::t_md_side r5_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_vld <= 1'b0;
        else          r5_vld <= md_vld;
    end

    always_ff @(posedge i_clk) begin
        r5_mag  <= mag_w;
        r5_side <= md_side;
    end

    // ---------------------------------------------------------------- stage M2: partial products
    logic               r6_vld;
    logic [63:0]        r6_lx, r6_hx, r6_ly, r6_hy;
    gf2d_pkg::t_md_side r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r6_vld <= 1'b0;
        else          r6_vld <= r5_vld;
    end

    always_ff @(posedge i_clk) begin
        r6_lx   <= 64'(r5_mag[31:0])  * 64'(r5_side.abs_x);
        r6_hx   <= 64'(r5_mag[63:32]) * 64'(r5_side.abs_x);
        r6_ly   <= 64'(r5_mag[31:0])  * 64'(r5_side.abs_y);
        r6_hy   <= 64'(r5_mag[63:32]) * 64'(r5_side.abs_y);
        r6_side <= r5_side;
    end

    // ---------------------------------------------------------------- stage M3: M*|d|
    logic               r7_vld;
    logic [NW-1:0]      r7_px, r7_py;
    logic [RW-1:0]      r7_root;
    gf2d_pkg::t_cp_side r7_cx, r7_cy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r7_vld <= 1'b0;
        else          r7_vld <= r6_vld;
    end

    always_ff @(posedge i_clk) begin
        r7_px   <= {r6_hx, 32'd0} + {32'd0, r6_lx};
        r7_py   <= {r6_hy, 32'd0} + {32'd0, r6_ly};
        r7_root <= r6_side.root;
        r7_cx.neg  <= r6_side.neg_x;
        r7_cx.zero <= r6_side.zero_x;
        r7_cy.neg  <= r6_side.neg_y;
        r7_cy.zero <= r6_side.zero_y;
    end

    // ---------------------------------------------------------------- component dividers
    // a zero root means coincident particles; both axes then carry the zero flag
    logic                                  cx_vld, cy_vld;
    logic [NW-1:0]                         cx_quo, cy_quo;
    logic [$bits(gf2d_pkg::t_cp_side)-1:0] cx_side_raw, cy_side_raw;
    gf2d_pkg::t_cp_side                    cx_side, cy_side;

    gf2d_div #(
        .NW (NW),
        .DW (RW),
        .SW ($bits(gf2d_pkg::t_cp_side))
    ) u_x_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_vld),
        .i_num   (r7_px),
        .i_den   (r7_root),
        .i_side  (r7_cx),
        .o_valid (cx_vld),
        .o_quo   (cx_quo),
        .o_side  (cx_side_raw)
    );

    gf2d_div #(
        .NW (NW),
        .DW (RW),
        .SW ($bits(gf2d_pkg::t_cp_side))
    ) u_y_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r7_vld),
        .i_num   (r7_py),
        .i_den   (r7_root),
        .i_side  (r7_cy),
        .o_valid (cy_vld),
        .o_quo   (cy_quo),
        .o_side  (cy_side_raw)
    );

    assign cx_side = gf2d_pkg::t_cp_side'(cx_side_raw);
    assign cy_side = gf2d_pkg::t_cp_side'(cy_side_raw);

    // ---------------------------------------------------------------- output: sign and saturate
    // truncation toward zero; clip to 0x7FFFFFFF / 0x80000000
    function automatic logic [PW:0] f_finish(input logic [NW-1:0] q, input gf2d_pkg::t_cp_side c);
        logic [PW-1:0] v;
        logic          sat;
        v   = '0;
        sat = 1'b0;
        if (c.zero) begin
            v = '0;
        end else if (!c.neg) begin
            if (q[NW-1:PW-1] != '0) begin
                sat = 1'b1;
                v   = 32'h7FFF_FFFF;
            end else begin
                v = q[PW-1:0];
            end
        end else begin
            if ((q[NW-1:PW] != '0) || (q[PW-1] && (q[PW-2:0] != '0))) begin
                sat = 1'b1;
                v   = 32'h8000_0000;
            end else begin
                v = ~q[PW-1:0] + 1'b1;
            end
        end
        return {sat, v};
    endfunction

    logic [PW:0] fin_x, fin_y;
    assign fin_x = f_finish(cx_quo, cx_side);
    assign fin_y = f_finish(cy_quo, cy_side);

    logic          r_out_vld;
    logic [PW-1:0] r_out_x, r_out_y;
    logic          r_out_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_out_vld <= 1'b0;
        else          r_out_vld <= cx_vld && cy_vld;
    end

    always_ff @(posedge i_clk) begin
        r_out_x   <= fin_x[PW-1:0];
        r_out_y   <= fin_y[PW-1:0];
        r_out_sat <= fin_x[PW] | fin_y[PW];
    end

    assign o_valid     = r_out_vld;
    assign o_force_x   = $signed(r_out_x);
    assign o_force_y   = $signed(r_out_y);
    assign o_saturated = r_out_sat;

endmodule

// ===== tb/sv/gravitational_force_2d_tb.sv =====
// Self-checking testbench for the 2-D gravity pipeline: directed and random pairs.
`timescale 1ns / 1ps
module gravitational_force_2d_tb;

    localparam int FB      = 16;
    localparam int LATENCY = 234;   // cycles from transfer to result through the top level

    typedef struct {
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic               sat;
    } t_force;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             start = 1'b0;
    logic                             busy;
    logic signed [31:0]               i_a_x = '0, i_a_y = '0, i_b_x = '0, i_b_y = '0;
    logic [31:0]                      i_mass_a = '0, i_mass_b = '0;
    logic                             i_cfg_we = 1'b0;
    logic [gf2d_pkg::IDX_W-1:0]       i_cfg_idx = '0;
    logic [63:0]                      i_cfg_data = '0;
    logic                             o_valid;
    logic signed [31:0]               o_force_x, o_force_y;
    logic                             o_saturated;

    // local copy of the configuration
    logic [31:0] grav_g;
    logic [63:0] clamp_lo, clamp_hi;

    t_force expected_forces[$];
    int     n_errors = 0;
    bit     idle_free = 1'b0;   // no gaps while set

    gravitational_force_2d #(.FRACTION_BITS(FB)) DUT (.*);

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("gravitational_force_2d_tb: done, errors");
        $finish;
    end

    // one force component: magnitude * |d| / root, signed and saturated
    function automatic logic [31:0] axis_force(input logic signed [33:0] d,
                                               input logic [63:0] mag,
                                               input logic [33:0] root,
                                               inout logic sat);
        logic [33:0]  ad;
        logic [127:0] q;
        if (d == 0 || root == 0) return '0;
        ad = (d < 0) ? -d : d;
        q  = ({64'd0, mag} * {94'd0, ad}) / {94'd0, root};
        if (d > 0) begin
            if (q > 128'h7FFF_FFFF) begin
                sat = 1'b1;
                return 32'h7FFF_FFFF;
            end
            return q[31:0];
        end
        if (q > 128'h8000_0000) begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return -q[31:0];
    endfunction

    function automatic t_force predict_force(input logic signed [31:0] ax, ay, bx, by,
                                             input logic [31:0] ma, mb);
        logic signed [33:0] dx, dy;
        logic [33:0]        adx, ady;
        logic [64:0]        d2;
        logic [63:0]        clamped, mag;
        logic [127:0]       num, quo;
        logic [33:0]        root, trial;
        t_force             f;
        dx = 34'(bx) - 34'(ax);
        dy = 34'(by) - 34'(ay);
        f = '{fx: '0, fy: '0, sat: 1'b0};
        if (dx == 0 && dy == 0) return f;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        d2 = 65'(64'(adx) * 64'(adx)) + 65'(64'(ady) * 64'(ady));
        clamped = (!d2[64] && d2[63:0] < clamp_lo) ? clamp_lo : d2[63:0];
        if (d2[64] || clamped > clamp_hi) clamped = clamp_hi;
        // G * mass_a keeps its low 64 bits, then times mass_b
        num = {64'd0, 64'(grav_g) * 64'(ma)} * {96'd0, mb};
        if (clamped == 0) begin
            mag = (num != 0) ? '1 : '0;
        end else begin
            quo = num / {64'd0, clamped};
            mag = (quo[127:64] != 0) ? '1 : quo[63:0];
        end
        root = '0;
        for (int b = 33; b >= 0; b--) begin
            trial = root | (34'd1 << b);
            if ({60'd0, trial} * {60'd0, trial} <= {29'd0, d2}) root = trial;
        end
        f.fx = axis_force(dx, mag, root, f.sat);
        f.fy = axis_force(dy, mag, root, f.sat);
        return f;
    endfunction

    // result checker: no hold-off on this side, every strobe is a transfer
    always @(posedge i_clk) begin
        t_force e;
        if (i_rst_n && o_valid) begin
            if (expected_forces.size() == 0) begin
                $error("unexpected result fx=%h fy=%h", o_force_x, o_force_y);
                n_errors++;
            end else begin
                e = expected_forces.pop_front();
                if (o_force_x !== e.fx) begin
                    $error("force_x exp %h got %h", e.fx, o_force_x);
                    n_errors++;
                end
                if (o_force_y !== e.fy) begin
                    $error("force_y exp %h got %h", e.fy, o_force_y);
                    n_errors++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %b got %b", e.sat, o_saturated);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_pair(input logic signed [31:0] ax, ay, bx, by,
                             input logic [31:0] ma, mb);
        if (!idle_free) begin
            while ($urandom_range(99) < 35) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
        start    <= 1'b1;
        i_a_x    <= ax;
        i_a_y    <= ay;
        i_b_x    <= bx;
        i_b_y    <= by;
        i_mass_a <= ma;
        i_mass_b <= mb;
        do @(posedge i_clk); while (busy);
        expected_forces.push_back(predict_force(ax, ay, bx, by, ma, mb));
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_forces.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [gf2d_pkg::IDX_W-1:0] idx, input logic [63:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            gf2d_pkg::CFG_GRAVITY: grav_g   = val[31:0];
            gf2d_pkg::CFG_MIN_D2:  clamp_lo = val;
            gf2d_pkg::CFG_MAX_D2:  clamp_hi = val;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic random_pair();
        logic [31:0] r[6];
        foreach (r[k]) r[k] = $urandom();
        // mostly short separations and modest masses so forces stay in range
        if ($urandom_range(3) != 0) begin
            r[2] = r[0] + 32'($signed($urandom_range(2 ** 20) - 2 ** 19));
            r[3] = r[1] + 32'($signed($urandom_range(2 ** 20) - 2 ** 19));
            r[4] = $urandom_range(2 ** 20);
            r[5] = $urandom_range(2 ** 20);
        end
        send_pair(r[0], r[1], r[2], r[3], r[4], r[5]);
    endtask

    task automatic test_directed();
        send_pair(0, 0, 0, 0, 32'h1_0000, 32'h1_0000);                // coincident
        send_pair(0, 0, 32'h3_0000, 0, 32'h1_0000, 32'h1_0000);       // y delta zero
        send_pair(0, 0, 0, 32'hFFFD_0000, 32'h2_0000, 32'h1_0000);    // x delta zero
        send_pair(32'h1_0000, 32'h1_0000, 32'h4_0000, 32'h5_0000, 32'h1_0000, 32'h1_0000);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, '1, '1);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1);
        send_pair(0, 0, 1, 1, 32'h1_0000, 32'h1_0000);                // inside lower clamp
        send_pair(0, 0, 1, 0, '1, '1);                               // saturates
        send_pair(0, 0, 32'h10_0000, 32'h10_0000, 0, 32'h1_0000);     // zero mass
        send_pair(5, 7, 2, 3, 32'h1_0000, 0);                        // zero mass
        send_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 32'h100, 32'h100);
    endtask

    task automatic test_clamps();
        // lower bound zero and upper bound zero: any nonzero numerator gives the capped magnitude
        write_reg(gf2d_pkg::CFG_MIN_D2, '0);
        write_reg(gf2d_pkg::CFG_MAX_D2, '0);
        send_pair(0, 0, 32'h2_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        send_pair(0, 0, 0, 0, 32'h1_0000, 32'h1_0000);
        send_pair(0, 0, 1, 1, 0, 32'h1_0000);
        drain();
        // lower above upper: upper wins
        write_reg(gf2d_pkg::CFG_MIN_D2, 64'h100_0000_0000);
        write_reg(gf2d_pkg::CFG_MAX_D2, 64'h4_0000_0000);
        send_pair(0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        send_pair(0, 0, 32'h40_0000, 0, 32'h1_0000, 32'h1_0000);
        drain();
        write_reg(gf2d_pkg::CFG_GRAVITY, '1);
        write_reg(gf2d_pkg::CFG_MIN_D2, '1);
        write_reg(gf2d_pkg::CFG_MAX_D2, '1);
        send_pair(0, 0, 32'h1_0000, 32'h1_0000, 32'h1_0000, 32'h1_0000);
        send_pair(0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1);
        drain();
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            idle_free = (n >= count / 3 && n < count / 2);
            random_pair();
        end
        idle_free = 1'b0;
    endtask

    initial begin
        grav_g   = 32'h1 << FB;
        clamp_lo = 64'h1 << (2 * FB);
        clamp_hi = '1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain();   // sender holds off until every result is back
        test_clamps();
        write_reg(gf2d_pkg::CFG_GRAVITY, 32'h1 << FB);
        write_reg(gf2d_pkg::CFG_MIN_D2, 64'h1 << (2 * FB));
        write_reg(gf2d_pkg::CFG_MAX_D2, '1);
        test_random(200);
        drain();
        write_reg(gf2d_pkg::CFG_GRAVITY, 32'h0_4000);
        write_reg(gf2d_pkg::CFG_MIN_D2, 64'h10_0000_0000);
        write_reg(gf2d_pkg::CFG_MAX_D2, 64'h1_0000_0000_0000);
        test_random(150);
        drain();
        write_reg(gf2d_pkg::CFG_GRAVITY, 0);
        test_random(20);
        drain();
        write_reg(gf2d_pkg::CFG_GRAVITY, $urandom());
        write_reg(gf2d_pkg::CFG_MIN_D2, {$urandom(), $urandom()} >> 20);
        write_reg(gf2d_pkg::CFG_MAX_D2, {$urandom(), $urandom()});
        test_random(130);
        drain();
        if (n_errors == 0 && expected_forces.size() == 0) begin
            $display("gravitational_force_2d_tb: done, clean");
        end else begin
            $display("gravitational_force_2d_tb: done, errors");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
design/gf2d_pkg.sv
design/gf2d_div.sv
design/gf2d_sqrt.sv
design/gravitational_force_2d.sv
tb/sv/gravitational_force_2d_tb.sv
